// ----- design/tfoc_pkg.sv -----
package tfoc_pkg;

  localparam int DATA_W        = 8;
  localparam int PC_W          = 8;
  localparam int PROG_DEPTH    = 256;
  localparam int NUM_REGS      = 4;
  localparam int PORT_IDX_W    = 3;
  localparam int NUM_PORTS_DEF = 8;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_SET_IN   = 2'd1,
    REQ_READ_OUT = 2'd2,
    REQ_EXEC     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_PORT = 2'd1,
    OP_LDI  = 2'd2,
    OP_BNE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [PC_W-1:0]       pc_now;
    logic [DATA_W-1:0]     reg_zero;
    logic [DATA_W-1:0]     reg_one;
    logic [DATA_W-1:0]     reg_two;
    logic [DATA_W-1:0]     reg_three;
    logic                  port_written;
    logic [PORT_IDX_W-1:0] port_index;
    logic [DATA_W-1:0]     port_value;
    logic [DATA_W-1:0]     read_value;
  } out_word_t;

  typedef struct packed {
    logic              fire;
    req_t              kind;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] payload;
  } exec_ctl_t;

endpackage

// ----- design/tfoc_ram.sv -----
module tfoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/tfoc_exec.sv -----
module tfoc_exec
  import tfoc_pkg::*;
#(
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  exec_ctl_t         ctl,
  input  logic [DATA_W-1:0] instr,
  output logic [PC_W-1:0]   pc,
  output out_word_t         result
);

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [DATA_W-1:0] rf_r [NUM_REGS];
  logic [DATA_W-1:0] rf_nxt [NUM_REGS];
  logic [DATA_W-1:0] in_port_r [NUM_PORTS];
  logic [DATA_W-1:0] in_port_nxt [NUM_PORTS];
  logic [DATA_W-1:0] out_port_r [NUM_PORTS];
  logic [DATA_W-1:0] out_port_nxt [NUM_PORTS];

  op_t                   op;
  logic [1:0]            rd, ra, rb;
  logic [PORT_IDX_W-1:0] pidx;
  logic [3:0]            off4;
  logic                  pidx_ok;
  logic [DATA_W-1:0]     in_sel;
  logic                  wr;
  logic [DATA_W-1:0]     rval;

  always_comb begin
    op   = op_t'(instr[7:6]);
    rd   = instr[5:4];
    ra   = instr[3:2];
    rb   = instr[1:0];
    pidx = instr[2:0];
    off4 = instr[5:2];

    pidx_ok = 1'b0;
    in_sel  = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (pidx == PORT_IDX_W'(i)) begin
        pidx_ok = 1'b1;
        in_sel  = in_port_r[i];
      end
    end

    pc_nxt = pc_r;
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    for (int i = 0; i < NUM_PORTS; i++) begin
      in_port_nxt[i]  = in_port_r[i];
      out_port_nxt[i] = out_port_r[i];
    end
    wr   = 1'b0;
    rval = '0;

    case (ctl.kind)
      REQ_SET_IN: begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          if (ctl.target == DATA_W'(i)) begin
            in_port_nxt[i] = ctl.payload;
          end
        end
      end
      REQ_READ_OUT: begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          if (ctl.target == DATA_W'(i)) begin
            rval = out_port_r[i];
          end
        end
      end
      REQ_EXEC: begin
        pc_nxt = pc_r + PC_W'(1);
        case (op)
          OP_ADD: begin
            rf_nxt[rd] = rf_r[ra] + rf_r[rb];
          end
          OP_PORT: begin
            if (!instr[3]) begin
              rf_nxt[rd] = in_sel;
            end else if (pidx_ok) begin
              wr = 1'b1;
              for (int i = 0; i < NUM_PORTS; i++) begin
                if (pidx == PORT_IDX_W'(i)) begin
                  out_port_nxt[i] = rf_r[rd];
                end
              end
            end
          end
          OP_LDI: begin
            rf_nxt[rd] = DATA_W'({6'b0, rb}) << {ra, 1'b0};
          end
          OP_BNE: begin
            if (rf_r[0] != rf_r[rb]) begin
              pc_nxt = pc_r + PC_W'({{4{off4[3]}}, off4});
            end
          end
          default: begin
            pc_nxt = pc_r;
          end
        endcase
      end
      default: begin
        pc_nxt = pc_r;
      end
    endcase

    result.pc_now       = pc_nxt;
    result.reg_zero     = rf_nxt[0];
    result.reg_one      = rf_nxt[1];
    result.reg_two      = rf_nxt[2];
    result.reg_three    = rf_nxt[3];
    result.port_written = wr;
    result.port_index   = wr ? pidx : '0;
    result.port_value   = wr ? rf_r[rd] : '0;
    result.read_value   = rval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        in_port_r[i]  <= '0;
        out_port_r[i] <= '0;
      end
    end else if (ctl.fire) begin
      pc_r <= pc_nxt;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        in_port_r[i]  <= in_port_nxt[i];
        out_port_r[i] <= out_port_nxt[i];
      end
    end
  end

  assign pc = pc_r;

endmodule

// ----- design/tiny_four_op_cpu_core_top.sv -----
// channel | ports                          | word
// input   | in_valid, in_stall, in_data    | in_word_t: req_type, target, payload
// output  | out_valid, out_stall, out_data | out_word_t: pc, registers, port results
//
// one result word per input word; an input word goes through a fetch stage and an
// execute stage, then waits in the output register
// non-execute words are taken every cycle while out_stall is low; an execute word
// stalls input, since the next fetch address is the pc the execute stage leaves
// after reset a clearing pass zeroes every program memory word, in_stall held high
// out_stall holds the output register and, once the execute stage is full, the input
module tiny_four_op_cpu_core_top
  import tfoc_pkg::*;
#(
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [PC_W-1:0] PROG_LAST = PC_W'(PROG_DEPTH - 1);

  logic            clr_busy_r;
  logic [PC_W-1:0] clr_addr_r;
  logic            s1_v_r;
  in_word_t        s1_r;
  logic            out_v_r;
  out_word_t       out_r;

  logic              accept;
  logic              s1_adv;
  logic              s1_exec;
  logic              ram_we;
  logic [PC_W-1:0]   ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DATA_W-1:0] instr;
  logic [PC_W-1:0]   pc;
  exec_ctl_t         ctl;
  out_word_t         result;

  assign s1_exec  = s1_v_r && (s1_r.req_type == REQ_EXEC);
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_v_r && !s1_adv) || s1_exec;
  assign accept   = in_valid && !in_stall;

  assign ram_we    = clr_busy_r || (accept && (in_data.req_type == REQ_LOAD));
  assign ram_waddr = clr_busy_r ? clr_addr_r : in_data.target;
  assign ram_wdata = clr_busy_r ? '0 : in_data.payload;
  assign ram_re    = accept && (in_data.req_type == REQ_EXEC);

  tfoc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PROG_DEPTH)
  ) u_prog_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pc),
    .rdata (instr)
  );

  always_comb begin
    ctl.fire    = s1_adv;
    ctl.kind    = req_t'(s1_r.req_type);
    ctl.target  = s1_r.target;
    ctl.payload = s1_r.payload;
  end

  tfoc_exec #(
    .NUM_PORTS (NUM_PORTS)
  ) u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .instr  (instr),
    .pc     (pc),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + PC_W'(1);
      if (clr_addr_r == PROG_LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall && !ram_re)
    else $error("word accepted during memory clearing pass");

  a_no_fetch_behind_exec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_exec |-> !ram_re)
    else $error("fetch issued while execute stage holds an instruction");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r && $stable(s1_r))
    else $error("execute stage lost its word while blocked");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r)
    else $error("result word dropped on its way to the output register");
`endif

endmodule
